// File: sv/mrb_pkg.sv
// Types, codes and fixed widths shared by the message ring buffer files.
package mrb_pkg;

   localparam int CNT_W      = 7;
   localparam int BYTE_W     = 8;
   localparam int STATUS_W   = 3;
   localparam int WAIT_W     = 4;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 7;
   localparam int SLOT_REG_W = 5;

   localparam logic [CNT_W-1:0]      BUFFER_SIZE_RESET = 7'd64;
   localparam logic [SLOT_REG_W-1:0] SLOT_COUNT_RESET  = 5'd16;

   typedef enum logic [0:0] {
      CMD_PUSH = 1'b0,
      CMD_POP  = 1'b1
   } command_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_STORED  = 3'd0,
      STAT_DROPPED = 3'd1,
      STAT_READ    = 3'd2,
      STAT_EMPTY   = 3'd3,
      STAT_DISCARD = 3'd4
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BUFFER_SIZE = 1'b0,
      CSR_SLOT_COUNT  = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_DESC,
      S_STREAM,
      S_DISCARD
   } state_type;

   typedef struct packed {
      logic              command;
      logic [BYTE_W-1:0] data_byte;
      logic [CNT_W-1:0]  message_length;
      logic [CNT_W-1:0]  read_limit;
   } req_word_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [BYTE_W-1:0]   out_byte;
      logic                last;
      logic [CNT_W-1:0]    delivered_length;
      logic [CNT_W-1:0]    bytes_used;
      logic [WAIT_W-1:0]   messages_waiting;
   } rsp_word_type;

endpackage

// File: sv/mrb_channel_if.sv
// Valid/ready channel interfaces for request and response words.
interface mrb_req_if;
   logic                 valid;
   logic                 ready;
   mrb_pkg::req_word_type word;

   modport source (output valid, output word, input ready);
   modport sink (input valid, input word, output ready);
   modport monitor (input valid, input word, input ready);
endinterface

interface mrb_rsp_if;
   logic                 valid;
   logic                 ready;
   mrb_pkg::rsp_word_type word;

   modport source (output valid, output word, input ready);
   modport sink (input valid, input word, output ready);
   modport monitor (input valid, input word, input ready);
endinterface

// File: sv/message_ring_buffer.sv
// Message queue: byte ring plus descriptor ring, with length-checked admission.
//
//  channel  | dir | payload                                           | handshake
//  req      | in  | command, data_byte, message_length, read_limit    | valid/ready
//  rsp      | out | status, out_byte, last, delivered_length,         | valid/ready
//           |     | bytes_used, messages_waiting                      |
//  csr      | in  | index, write data                                 | write enable
//
// A push or an empty-queue pop loads its response word at the accept edge.
// A non-empty pop reads the descriptor, issues the first byte read, then loads one
// response word per cycle while not stalled; a discard loads its word after the
// descriptor read. Input is held off until the last word of a pop is loaded.
// Synchronous reset clears control state; memories start undefined and need no sweep.
// A csr write clears the queue. A stalled response holds the sequencer.
module message_ring_buffer #(
   parameter int BUF_DEPTH = 64,
   parameter int SLOTS     = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_enable,
   input  logic [mrb_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [mrb_pkg::CSR_DATA_W-1:0]    csr_write_data,
   mrb_req_if.sink                           req_stream,
   mrb_rsp_if.source                         rsp_stream
);
   import mrb_pkg::*;

   localparam int AW = $clog2(BUF_DEPTH);
   localparam int SW = $clog2(SLOTS);

   function automatic logic [CNT_W-1:0] step_wrap(logic [CNT_W-1:0] x,
                                                  logic [CNT_W-1:0] size);
      logic [CNT_W-1:0] nx;
      nx = x + 1'b1;
      return (nx >= size) ? '0 : nx;
   endfunction

   function automatic logic [CNT_W-1:0] count_waiting(logic [SW-1:0] w,
                                                      logic [SW-1:0] r,
                                                      logic [CNT_W-1:0] size);
      logic [CNT_W-1:0] we;
      logic [CNT_W-1:0] re;
      we = CNT_W'(w);
      re = CNT_W'(r);
      return (we >= re) ? (we - re) : (size - re + we);
   endfunction

   logic [CNT_W-1:0]      buffer_size_ff;
   logic [SLOT_REG_W-1:0] slot_count_ff;
   logic [CNT_W-1:0]      bs;
   logic [CNT_W-1:0]      sc;
   logic [CNT_W-1:0]      slot_ext;

   state_type state_ff, state_in;

   logic [AW-1:0]    wo_ff, wo_in;
   logic [SW-1:0]    wi_ff, wi_in;
   logic [SW-1:0]    ri_ff, ri_in;
   logic [CNT_W-1:0] used_ff, used_in;
   logic [CNT_W-1:0] pending_ff, pending_in;
   logic [CNT_W-1:0] cur_len_ff, cur_len_in;
   logic             dropping_ff, dropping_in;
   logic [CNT_W-1:0] limit_ff, limit_in;
   logic [CNT_W-1:0] n_ff, n_in;
   logic [CNT_W-1:0] issue_left_ff, issue_left_in;
   logic [CNT_W-1:0] load_cnt_ff, load_cnt_in;
   logic [AW-1:0]    rd_pos_ff, rd_pos_in;
   logic             data_pend_ff, data_pend_in;

   logic [BYTE_W-1:0] byte_mem [BUF_DEPTH];
   logic [AW-1:0]     desc_start_mem [SLOTS];
   logic [CNT_W-1:0]  desc_len_mem [SLOTS];
   logic [BYTE_W-1:0] byte_rd_ff;
   logic [AW-1:0]     desc_start_rd_ff;
   logic [CNT_W-1:0]  desc_len_rd_ff;

   logic byte_we;
   logic desc_we;
   logic desc_re;

   logic         out_load;
   logic         out_free;
   rsp_word_type out_word;

   logic             accept;
   logic             is_pop;
   logic             queue_empty;
   logic             first_byte;
   logic [CNT_W-1:0] mlen_eff;
   logic [CNT_W-1:0] len_cur;
   logic             fits;
   logic             drop_cur;
   logic [CNT_W:0]   pend_next;
   logic             msg_done;
   logic [CNT_W-1:0] waiting_now;
   logic [CNT_W-1:0] n_cur;
   logic [CNT_W-1:0] used_after_pop;
   logic             stream_load;
   logic             stream_issue;
   logic             load_last;

   // saturate the ring sizes into their legal ranges
   assign slot_ext = CNT_W'(slot_count_ff);
   assign bs = (buffer_size_ff < CNT_W'(2)) ? CNT_W'(2) :
               ((buffer_size_ff > CNT_W'(BUF_DEPTH)) ? CNT_W'(BUF_DEPTH) : buffer_size_ff);
   assign sc = (slot_ext < CNT_W'(2)) ? CNT_W'(2) :
               ((slot_ext > CNT_W'(SLOTS)) ? CNT_W'(SLOTS) : slot_ext);

   assign req_stream.ready = (state_ff == S_IDLE) && out_free;

   assign accept      = req_stream.valid && req_stream.ready;
   assign is_pop      = req_stream.word.command == CMD_POP;
   assign queue_empty = wi_ff == ri_ff;

   assign first_byte  = pending_ff == '0;
   assign mlen_eff    = (req_stream.word.message_length == '0) ? CNT_W'(1) :
                        req_stream.word.message_length;
   assign waiting_now = count_waiting(wi_ff, ri_ff, sc);
   assign fits        = ({1'b0, used_ff} + {1'b0, mlen_eff} <= {1'b0, bs}) &&
                        (waiting_now < sc - 1'b1);
   assign len_cur     = first_byte ? mlen_eff : cur_len_ff;
   assign drop_cur    = first_byte ? !fits : dropping_ff;
   assign pend_next   = {1'b0, pending_ff} + 1'b1;
   assign msg_done    = pend_next >= {1'b0, len_cur};

   assign n_cur          = (desc_len_rd_ff < limit_ff) ? desc_len_rd_ff : limit_ff;
   assign used_after_pop = (used_ff >= desc_len_rd_ff) ? (used_ff - desc_len_rd_ff) : '0;

   assign stream_load  = (state_ff == S_STREAM) && data_pend_ff && out_free;
   assign stream_issue = (state_ff == S_STREAM) && (issue_left_ff != '0) &&
                         (!data_pend_ff || stream_load);
   assign load_last    = (load_cnt_ff + 1'b1) == n_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept && is_pop && !queue_empty) begin
               state_in = S_DESC;
            end
         end
         S_DESC: begin
            state_in = (n_cur == '0) ? S_DISCARD : S_STREAM;
         end
         S_DISCARD: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         S_STREAM: begin
            if (stream_load && load_last) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      wo_in         = wo_ff;
      wi_in         = wi_ff;
      ri_in         = ri_ff;
      used_in       = used_ff;
      pending_in    = pending_ff;
      cur_len_in    = cur_len_ff;
      dropping_in   = dropping_ff;
      limit_in      = limit_ff;
      n_in          = n_ff;
      issue_left_in = issue_left_ff;
      load_cnt_in   = load_cnt_ff;
      rd_pos_in     = rd_pos_ff;
      data_pend_in  = data_pend_ff;
      byte_we       = 1'b0;
      desc_we       = 1'b0;
      desc_re       = 1'b0;
      out_load      = 1'b0;
      out_word      = '0;
      out_word.last = 1'b1;

      case (state_ff)
         S_IDLE: begin
            if (accept && !is_pop) begin
               desc_we    = first_byte;
               cur_len_in = len_cur;
               if (!drop_cur) begin
                  byte_we         = 1'b1;
                  wo_in           = AW'(step_wrap(CNT_W'(wo_ff), bs));
                  used_in         = used_ff + 1'b1;
                  out_word.status = STAT_STORED;
               end else begin
                  out_word.status = STAT_DROPPED;
               end
               if (msg_done) begin
                  pending_in  = '0;
                  dropping_in = 1'b0;
                  if (!drop_cur) begin
                     wi_in = SW'(step_wrap(CNT_W'(wi_ff), sc));
                  end
               end else begin
                  pending_in  = pend_next[CNT_W-1:0];
                  dropping_in = drop_cur;
               end
               out_load = 1'b1;
            end else if (accept && is_pop) begin
               if (queue_empty) begin
                  out_word.status = STAT_EMPTY;
                  out_load        = 1'b1;
               end else begin
                  desc_re  = 1'b1;
                  limit_in = req_stream.word.read_limit;
               end
            end
         end
         S_DESC: begin
            n_in          = n_cur;
            issue_left_in = n_cur;
            load_cnt_in   = '0;
            rd_pos_in     = desc_start_rd_ff;
            data_pend_in  = 1'b0;
            used_in       = used_after_pop;
            ri_in         = SW'(step_wrap(CNT_W'(ri_ff), sc));
         end
         S_DISCARD: begin
            out_word.status = STAT_DISCARD;
            out_load        = out_free;
         end
         S_STREAM: begin
            if (stream_issue) begin
               rd_pos_in     = AW'(step_wrap(CNT_W'(rd_pos_ff), bs));
               issue_left_in = issue_left_ff - 1'b1;
            end
            if (stream_issue) begin
               data_pend_in = 1'b1;
            end else if (stream_load) begin
               data_pend_in = 1'b0;
            end
            if (stream_load) begin
               load_cnt_in = load_cnt_ff + 1'b1;
            end
            out_word.status           = STAT_READ;
            out_word.out_byte         = byte_rd_ff;
            out_word.last             = load_last;
            out_word.delivered_length = n_ff;
            out_load                  = stream_load;
         end
         default: ;
      endcase

      out_word.bytes_used       = used_in;
      out_word.messages_waiting = WAIT_W'(count_waiting(wi_in, ri_in, sc));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buffer_size_ff <= BUFFER_SIZE_RESET;
         slot_count_ff  <= SLOT_COUNT_RESET;
         state_ff       <= S_IDLE;
         wo_ff          <= '0;
         wi_ff          <= '0;
         ri_ff          <= '0;
         used_ff        <= '0;
         pending_ff     <= '0;
         dropping_ff    <= 1'b0;
         data_pend_ff   <= 1'b0;
         issue_left_ff  <= '0;
         load_cnt_ff    <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_BUFFER_SIZE: buffer_size_ff <= csr_write_data;
            CSR_SLOT_COUNT:  slot_count_ff  <= csr_write_data[SLOT_REG_W-1:0];
            default: ;
         endcase
         wo_ff       <= '0;
         wi_ff       <= '0;
         ri_ff       <= '0;
         used_ff     <= '0;
         pending_ff  <= '0;
         dropping_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         wo_ff         <= wo_in;
         wi_ff         <= wi_in;
         ri_ff         <= ri_in;
         used_ff       <= used_in;
         pending_ff    <= pending_in;
         dropping_ff   <= dropping_in;
         data_pend_ff  <= data_pend_in;
         issue_left_ff <= issue_left_in;
         load_cnt_ff   <= load_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_len_ff <= cur_len_in;
      limit_ff   <= limit_in;
      n_ff       <= n_in;
      rd_pos_ff  <= rd_pos_in;
   end

   always_ff @(posedge clock) begin
      if (byte_we) begin
         byte_mem[wo_ff] <= req_stream.word.data_byte;
      end
      if (stream_issue) begin
         byte_rd_ff <= byte_mem[rd_pos_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (desc_we) begin
         desc_start_mem[wi_ff] <= wo_ff;
         desc_len_mem[wi_ff]   <= mlen_eff;
      end
      if (desc_re) begin
         desc_start_rd_ff <= desc_start_mem[ri_ff];
         desc_len_rd_ff   <= desc_len_mem[ri_ff];
      end
   end

   mrb_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .load       (out_load),
      .word_in    (out_word),
      .free       (out_free),
      .rsp_stream (rsp_stream)
   );

endmodule

// File: sv/mrb_out_stage.sv
// Response output register: holds one word until the sink takes it.
module mrb_out_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  mrb_pkg::rsp_word_type word_in,
   output logic                  free,
   mrb_rsp_if.source             rsp_stream
);
   import mrb_pkg::*;

   logic         valid_ff;
   rsp_word_type word_ff;

   assign free             = !valid_ff || rsp_stream.ready;
   assign rsp_stream.valid = valid_ff;
   assign rsp_stream.word  = word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (rsp_stream.ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         word_ff <= word_in;
      end
   end

endmodule

// File: sv/mrb_checker.sv
// Port-level assertions for the message ring buffer, bound to the top level.
module mrb_checker #(
   parameter int BUF_DEPTH = 64
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input mrb_pkg::rsp_word_type rsp_word
);
   import mrb_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word))
      else $error("response word changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_single_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.status != STAT_READ |-> rsp_word.last)
      else $error("non-read response without last");

   a_read_length: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         ((rsp_word.status == STAT_READ) == (rsp_word.delivered_length != '0)))
      else $error("delivered length does not match status");

   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_word.bytes_used <= CNT_W'(BUF_DEPTH))
      else $error("bytes used beyond ring depth");

endmodule

bind message_ring_buffer mrb_checker #(.BUF_DEPTH(BUF_DEPTH)) u_mrb_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_stream.valid),
   .rsp_ready (rsp_stream.ready),
   .rsp_word  (rsp_stream.word)
);
